// ===== hw/rtl/ofwsm_pkg.sv =====
package ofwsm_pkg;

    typedef struct packed {
        logic [2:0]         robot_index;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic signed [15:0] heading;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  robot_id;
        logic [15:0] wheel1_speed;
        logic        wheel1_dir;
        logic [15:0] wheel2_speed;
        logic        wheel2_dir;
        logic [15:0] wheel3_speed;
        logic        wheel3_dir;
        logic [15:0] wheel4_speed;
        logic        wheel4_dir;
    } wheel_t;

    localparam int CORDIC_STEPS = 16;

    localparam logic signed [33:0] Q30_PI      = 34'sd3373259426;
    localparam logic signed [33:0] Q30_HALF_PI = 34'sd1686629713;
    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

    localparam logic signed [15:0] WHEEL_SIN [4] =
        '{16'sd28375, 16'sd23175, -16'sd23171, -16'sd28378};
    localparam logic signed [15:0] WHEEL_COS [4] =
        '{16'sd16390, -16'sd23166, -16'sd23170, 16'sd16384};

    function automatic logic signed [31:0] atan_q30(input logic [3:0] step);
        logic signed [31:0] a;
        unique case (step)
            4'd0:  a = 32'sh3243F6A8;
            4'd1:  a = 32'sh1DAC6705;
            4'd2:  a = 32'sh0FADBAFC;
            4'd3:  a = 32'sh07F56EA6;
            4'd4:  a = 32'sh03FEAB76;
            4'd5:  a = 32'sh01FFD55B;
            4'd6:  a = 32'sh00FFFAAA;
            4'd7:  a = 32'sh007FFF55;
            4'd8:  a = 32'sh003FFFEA;
            4'd9:  a = 32'sh001FFFFD;
            4'd10: a = 32'sh000FFFFF;
            4'd11: a = 32'sh0007FFFF;
            4'd12: a = 32'sh0003FFFF;
            4'd13: a = 32'sh0001FFFF;
            4'd14: a = 32'sh0000FFFF;
            4'd15: a = 32'sh00007FFF;
        endcase
        return a;
    endfunction

endpackage

// ===== hw/rtl/omni_four_wheel_speed_mixer.sv =====
// Four-wheel omni inverse kinematics: each command transaction carries a field
// velocity and a Q3.13 heading, and produces one transaction with four wheel speed
// magnitudes and direction bits for the same robot index. The block takes one
// transaction every cycle while no result is stalled at the output. Its pipeline
// is built from the sixteen CORDIC step stages plus the heading reduction,
// rounding, rotation and wheel projection stages. The whole pipeline holds while
// a finished result is stalled at the output.
module omni_four_wheel_speed_mixer
    import ofwsm_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   cmd_valid,
    output logic   cmd_stall,
    input  cmd_t   cmd_data,
    output logic   wheel_valid,
    input  logic   wheel_stall,
    output wheel_t wheel_data
);

    localparam int ST_LAST_STEP = CORDIC_STEPS;
    localparam int ST_FLIP      = CORDIC_STEPS + 1;
    localparam int ST_ROUND     = CORDIC_STEPS + 2;
    localparam int ST_PROD      = CORDIC_STEPS + 3;
    localparam int ST_ROT       = CORDIC_STEPS + 4;
    localparam int ST_WPROD     = CORDIC_STEPS + 5;
    localparam int ST_WSUM      = CORDIC_STEPS + 6;
    localparam int ST_OUT       = CORDIC_STEPS + 7;
    localparam int DEPTH        = ST_OUT + 1;

    function automatic logic signed [15:0] sat_q15(input logic signed [31:0] v);
        logic signed [32:0] r;
        logic signed [32:0] q;
        logic signed [15:0] s;
        r = 33'(v) + 33'sd16384;
        q = r >>> 15;
        if (q > 33'sd32767) begin
            s = 16'sd32767;
        end
        else if (q < -33'sd32768) begin
            s = -16'sd32768;
        end
        else begin
            s = q[15:0];
        end
        return s;
    endfunction

    logic advance;

    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;

    logic signed [31:0] x_reg    [0:ST_LAST_STEP];
    logic signed [31:0] x_next   [0:ST_LAST_STEP];
    logic signed [31:0] y_reg    [0:ST_LAST_STEP];
    logic signed [31:0] y_next   [0:ST_LAST_STEP];
    logic signed [31:0] z_reg    [0:ST_LAST_STEP];
    logic signed [31:0] z_next   [0:ST_LAST_STEP];
    logic               flip_reg [0:ST_LAST_STEP];
    logic               flip_next[0:ST_LAST_STEP];

    logic signed [15:0] vx_reg   [0:ST_ROUND];
    logic signed [15:0] vx_next  [0:ST_ROUND];
    logic signed [15:0] vy_reg   [0:ST_ROUND];
    logic signed [15:0] vy_next  [0:ST_ROUND];
    logic [2:0]         id_reg   [0:ST_WSUM];
    logic [2:0]         id_next  [0:ST_WSUM];

    logic signed [33:0] theta;
    logic signed [33:0] theta_red;
    logic               theta_flip;

    logic signed [31:0] fx_reg, fx_next, fy_reg, fy_next;
    logic signed [15:0] c_reg, c_next, s_reg, s_next;
    logic signed [31:0] p_xc_reg, p_xc_next, p_ys_reg, p_ys_next;
    logic signed [31:0] p_xs_reg, p_xs_next, p_yc_reg, p_yc_next;
    logic signed [32:0] rx_reg, rx_next, ry_reg, ry_next;
    logic signed [48:0] pa_reg   [4];
    logic signed [48:0] pa_next  [4];
    logic signed [48:0] pb_reg   [4];
    logic signed [48:0] pb_next  [4];
    logic signed [49:0] v_reg    [4];
    logic signed [49:0] v_next   [4];

    wheel_t             wheel_reg;
    wheel_t             wheel_next;
    logic [15:0]        mag      [4];
    logic               neg      [4];

    assign advance     = !(valid_reg[ST_OUT] && wheel_stall);
    assign cmd_stall   = !advance;
    assign wheel_valid = valid_reg[ST_OUT];
    assign wheel_data  = wheel_reg;
    assign valid_next  = {valid_reg[DEPTH-2:0], cmd_valid};

    always_comb
    begin
        theta = 34'sd0 - (34'(cmd_data.heading) <<< 17);
        if (theta > Q30_HALF_PI) begin
            theta_red  = theta - Q30_PI;
            theta_flip = 1'b1;
        end
        else if (theta < -Q30_HALF_PI) begin
            theta_red  = theta + Q30_PI;
            theta_flip = 1'b1;
        end
        else begin
            theta_red  = theta;
            theta_flip = 1'b0;
        end
    end

    always_comb
    begin
        x_next[0]    = CORDIC_GAIN;
        y_next[0]    = 32'sd0;
        z_next[0]    = theta_red[31:0];
        flip_next[0] = theta_flip;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            flip_next[i+1] = flip_reg[i];
            if (z_reg[i] >= 32'sd0) begin
                x_next[i+1] = x_reg[i] - (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] + (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i] - atan_q30(4'(i));
            end
            else begin
                x_next[i+1] = x_reg[i] + (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] - (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i] + atan_q30(4'(i));
            end
        end
    end

    always_comb
    begin
        vx_next[0] = cmd_data.vel_x;
        vy_next[0] = cmd_data.vel_y;
        id_next[0] = cmd_data.robot_index;
        for (int k = 1; k <= ST_ROUND; k++) begin
            vx_next[k] = vx_reg[k-1];
            vy_next[k] = vy_reg[k-1];
        end
        for (int k = 1; k <= ST_WSUM; k++) begin
            id_next[k] = id_reg[k-1];
        end
    end

    always_comb
    begin
        fx_next   = flip_reg[ST_LAST_STEP] ? -x_reg[ST_LAST_STEP] : x_reg[ST_LAST_STEP];
        fy_next   = flip_reg[ST_LAST_STEP] ? -y_reg[ST_LAST_STEP] : y_reg[ST_LAST_STEP];
        c_next    = sat_q15(fx_reg);
        s_next    = sat_q15(fy_reg);
        p_xc_next = 32'(vx_reg[ST_ROUND]) * 32'(c_reg);
        p_ys_next = 32'(vy_reg[ST_ROUND]) * 32'(s_reg);
        p_xs_next = 32'(vx_reg[ST_ROUND]) * 32'(s_reg);
        p_yc_next = 32'(vy_reg[ST_ROUND]) * 32'(c_reg);
        rx_next   = 33'(p_xc_reg) - 33'(p_ys_reg);
        ry_next   = 33'(p_xs_reg) + 33'(p_yc_reg);
        for (int k = 0; k < 4; k++) begin
            pa_next[k] = 49'(rx_reg) * 49'(WHEEL_SIN[k]);
            pb_next[k] = 49'(ry_reg) * 49'(WHEEL_COS[k]);
            if (k == 0 || k == 3) begin
                v_next[k] = 50'sd0 - 50'(pa_reg[k]) - 50'(pb_reg[k]);
            end
            else begin
                v_next[k] = 50'sd0 - 50'(pa_reg[k]) + 50'(pb_reg[k]);
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++) begin
            logic [49:0] absv;
            neg[k] = v_reg[k][49];
            absv   = neg[k] ? 50'(-v_reg[k]) : 50'(v_reg[k]);
            if (absv[49:30] > 20'd65535) begin
                mag[k] = 16'hFFFF;
            end
            else begin
                mag[k] = absv[45:30];
            end
        end
        wheel_next.robot_id     = id_reg[ST_WSUM];
        wheel_next.wheel1_speed = mag[0];
        wheel_next.wheel1_dir   = !neg[0];
        wheel_next.wheel2_speed = mag[1];
        wheel_next.wheel2_dir   = !neg[1];
        wheel_next.wheel3_speed = mag[2];
        wheel_next.wheel3_dir   = neg[2];
        wheel_next.wheel4_speed = mag[3];
        wheel_next.wheel4_dir   = neg[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
        end
        else if (advance) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            z_reg     <= z_next;
            flip_reg  <= flip_next;
            vx_reg    <= vx_next;
            vy_reg    <= vy_next;
            id_reg    <= id_next;
            fx_reg    <= fx_next;
            fy_reg    <= fy_next;
            c_reg     <= c_next;
            s_reg     <= s_next;
            p_xc_reg  <= p_xc_next;
            p_ys_reg  <= p_ys_next;
            p_xs_reg  <= p_xs_next;
            p_yc_reg  <= p_yc_next;
            rx_reg    <= rx_next;
            ry_reg    <= ry_next;
            pa_reg    <= pa_next;
            pb_reg    <= pb_next;
            v_reg     <= v_next;
            wheel_reg <= wheel_next;
        end
    end

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> (wheel_valid && wheel_stall))
        else $error("Command stalled while the output register was free.");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> (valid_reg == $past(valid_reg)))
        else $error("Pipeline valid bits changed during an output stall.");

    a_shift: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (valid_reg[DEPTH-1:1] == $past(valid_reg[DEPTH-2:0])))
        else $error("A transaction was lost or repeated inside the pipeline.");

endmodule
